>>> rtl/core/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types, constants and the half-step coil table for the stepper
// packet controller.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int unsigned DutyW   = 10;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned ByteW   = 8;

  localparam logic [DutyW-1:0]   OnDutyReset = 10'd250;
  localparam logic [PeriodW-1:0] PeriodReset = 16'd1000;
  localparam logic [ByteW-1:0]   StartByte   = 8'hFF;

  // Packet commands
  localparam logic [ByteW-1:0] CmdRunCcw  = 8'd1;
  localparam logic [ByteW-1:0] CmdRunCw   = 8'd2;
  localparam logic [ByteW-1:0] CmdStepCcw = 8'd3;
  localparam logic [ByteW-1:0] CmdStepCw  = 8'd4;

  // Rotation direction
  typedef enum logic [1:0] {
    DirHold = 2'd0,
    DirCcw  = 2'd1,
    DirCw   = 2'd2
  } stp_dir_e;

  // Why a pattern was driven
  localparam logic CauseSingle = 1'b0;
  localparam logic CauseTimed  = 1'b1;

  // One result beat
  typedef struct packed {
    logic             cause;
    logic [IdxW-1:0]  phase_index;
    logic [DutyW-1:0] duty_b2;
    logic [DutyW-1:0] duty_b1;
    logic [DutyW-1:0] duty_a2;
    logic [DutyW-1:0] duty_a1;
  } stp_result_t;

  // Energized coils per half step: bit0 A1, bit1 A2, bit2 B1, bit3 B2
  function automatic logic [3:0] coil_pattern(input logic [IdxW-1:0] idx);
    logic [3:0] pat;
    case (idx)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h5;
      3'd2:    pat = 4'h4;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h2;
      3'd5:    pat = 4'hA;
      3'd6:    pat = 4'h8;
      3'd7:    pat = 4'h9;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

  // Build the result beat for one index
  function automatic stp_result_t make_result(input logic [IdxW-1:0]  idx,
                                              input logic [DutyW-1:0] duty,
                                              input logic             why);
    stp_result_t r;
    logic [3:0]  pat;
    pat           = coil_pattern(idx);
    r.duty_a1     = pat[0] ? duty : '0;
    r.duty_a2     = pat[1] ? duty : '0;
    r.duty_b1     = pat[2] ? duty : '0;
    r.duty_b2     = pat[3] ? duty : '0;
    r.phase_index = idx;
    r.cause       = why;
    return r;
  endfunction

endpackage

>>> rtl/core/stp_core.sv
// ----------------------------------------------------------------------------
// stp_core
// Packet assembly, step timer and half-step index. Each accepted beat
// updates the registered state and may raise one result.
// ----------------------------------------------------------------------------
module stp_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [stp_pkg::DutyW-1:0]   cfg_wdata_i,
  input  logic                        accept_i,
  input  logic                        func_i,
  input  logic [stp_pkg::ByteW-1:0]   rx_data_i,
  output logic                        emit_o,
  output stp_pkg::stp_result_t        result_o
);
  import stp_pkg::*;

  logic [DutyW-1:0]   on_duty_q;
  logic [2:0]         byte_count_q, byte_count_d;
  logic [ByteW-1:0]   pkt_q [4];
  logic [PeriodW-1:0] period_q, period_d;
  logic [PeriodW-1:0] tick_q, tick_d;
  logic               running_q, running_d;
  stp_dir_e           dir_q, dir_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic               pkt_we;
  logic [ByteW-1:0]   dh, dl;
  logic [ByteW-1:0]   cmd;

  assign cmd = pkt_q[1];

  // Escape byte forces data bytes to all ones
  always_comb begin
    dl = rx_data_i[0] ? StartByte : pkt_q[3];
    dh = rx_data_i[1] ? StartByte : pkt_q[2];
  end

  // Next state and result for one beat
  always_comb begin
    byte_count_d = byte_count_q;
    period_d     = period_q;
    tick_d       = tick_q;
    running_d    = running_q;
    dir_d        = dir_q;
    idx_d        = idx_q;
    pkt_we       = 1'b0;
    emit_o       = 1'b0;
    result_o     = make_result(idx_q, on_duty_q, CauseTimed);
    if (accept_i) begin
      if (func_i) begin
        // timer tick
        if (running_q && (period_q != '0)) begin
          if (tick_q == period_q) begin
            tick_d = '0;
            emit_o = 1'b1;
            case (dir_q)
              DirCcw:  idx_d = idx_q - 1'b1;
              DirCw:   idx_d = idx_q + 1'b1;
              default: idx_d = idx_q;
            endcase
          end else begin
            tick_d = tick_q + 1'b1;
          end
        end
      end else if (!byte_count_q[2]) begin
        // gather start, command and data bytes
        pkt_we       = 1'b1;
        byte_count_d = byte_count_q + 1'b1;
      end else begin
        // escape byte closes the packet
        byte_count_d = '0;
        if (pkt_q[0] == StartByte) begin
          case (cmd)
            CmdRunCcw: begin
              dir_d     = DirCcw;
              running_d = 1'b1;
              period_d  = {dh, dl};
              idx_d     = idx_q - 1'b1;
            end
            CmdRunCw: begin
              dir_d     = DirCw;
              running_d = 1'b1;
              period_d  = {dh, dl};
              idx_d     = idx_q + 1'b1;
            end
            CmdStepCcw: begin
              dir_d     = DirHold;
              running_d = 1'b0;
              idx_d     = idx_q - 1'b1;
              emit_o    = 1'b1;
              result_o  = make_result(idx_q - 1'b1, on_duty_q, CauseSingle);
            end
            CmdStepCw: begin
              dir_d     = DirHold;
              running_d = 1'b0;
              idx_d     = idx_q + 1'b1;
              emit_o    = 1'b1;
              result_o  = make_result(idx_q + 1'b1, on_duty_q, CauseSingle);
            end
            default: begin
              dir_d = DirHold;
            end
          endcase
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_duty_q    <= OnDutyReset;
      byte_count_q <= '0;
      period_q     <= PeriodReset;
      tick_q       <= '0;
      running_q    <= 1'b1;
      dir_q        <= DirHold;
      idx_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        on_duty_q <= cfg_wdata_i;
      end
      byte_count_q <= byte_count_d;
      period_q     <= period_d;
      tick_q       <= tick_d;
      running_q    <= running_d;
      dir_q        <= dir_d;
      idx_q        <= idx_d;
    end
  end

  // Packet byte store, no reset
  always_ff @(posedge clk_i) begin
    if (pkt_we) begin
      pkt_q[byte_count_q[1:0]] <= rx_data_i;
    end
  end

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_count_q <= 3'd4) else $error("byte count past escape slot");

  a_emit_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |-> accept_i) else $error("result raised without a beat");

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> $stable(idx_q)) else $error("index moved without a beat");

endmodule

>>> rtl/core/stp_skid.sv
// ----------------------------------------------------------------------------
// stp_skid
// Two-entry output buffer: a result register plus one skid slot, so the
// input side stays ready while one result waits on the receiver.
// ----------------------------------------------------------------------------
module stp_skid (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  stp_pkg::stp_result_t in_data_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output stp_pkg::stp_result_t out_data_o
);
  import stp_pkg::*;

  logic        out_valid_q, skid_valid_q;
  stp_result_t out_data_q, skid_data_q;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_valid_i;
      end
    end else if (in_valid_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      out_data_q <= skid_valid_q ? skid_data_q : in_data_i;
    end else if (in_valid_i) begin
      skid_data_q <= in_data_i;
    end
  end

  // Checks
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q) else $error("skid full with output empty");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !in_valid_i) else $error("result pushed into full buffer");

  a_stall_parks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && in_valid_i) |=> skid_valid_q)
    else $error("stalled result not parked");

endmodule

>>> rtl/core/stepper_half_step_packet_controller.sv
// ----------------------------------------------------------------------------
// stepper_half_step_packet_controller
// Half-step stepper sequencer fed by serial packet bytes and timer ticks.
// ----------------------------------------------------------------------------
// Input stream: one beat per received byte (tuser 0) or per 1 MHz timer tick
// (tuser 1). Bytes form packets of five: start (255), command, data high,
// data low, escape. Commands 1/2 step once CCW/CW and run the timer with the
// 16-bit period; commands 3/4 stop the timer and drive one step at once.
// Output stream: one beat per driven pattern, with the four coil compare
// values, the phase index and the cause (tuser: 0 single step, 1 timed).
// A result is registered in the output buffer before it appears on the
// output. Throughput: one input beat per cycle while tready is high; all
// state updates are a 16-bit compare/increment and small muxes between the
// input and the result register.
// Stall: a two-entry output buffer keeps tready high while one result
// waits; with both entries full the input stalls until the receiver takes
// a beat.
// Reset: period 1000, timer running, direction hold, index 0, on_duty 250.
// User writes on_duty via cfg_we_i / cfg_wdata_i only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module stepper_half_step_packet_controller (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [stp_pkg::DutyW-1:0] cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] rx_data
  input  logic                      s_axis_tuser,   // [0] func
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [9:0] duty_a1, [19:10] duty_a2, [29:20] duty_b1, [39:30] duty_b2,
  // [42:40] phase_index, [47:43] zero
  output logic [47:0]               m_axis_tdata,
  output logic                      m_axis_tuser    // [0] cause
);
  import stp_pkg::*;

  logic        accept;
  logic        emit;
  stp_result_t result;
  stp_result_t out_res;

  assign accept = s_axis_tvalid && s_axis_tready;

  // State update per beat
  stp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .func_i      (s_axis_tuser),
    .rx_data_i   (s_axis_tdata),
    .emit_o      (emit),
    .result_o    (result)
  );

  // Result register with skid slot
  stp_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (emit),
    .in_data_i   (result),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  // Output packing
  assign m_axis_tdata = {5'b0, out_res.phase_index, out_res.duty_b2, out_res.duty_b1,
                         out_res.duty_a2, out_res.duty_a1};
  assign m_axis_tuser = out_res.cause;

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the half-step stepper packet controller.
// ----------------------------------------------------------------------------
// Byte and tick beats go into the slave stream. A sequencer model in the
// bench tracks packet gathering, the step timer, the direction and the phase
// index, and queues the coil pattern each beat should produce. Every beat
// on the master stream is checked field by field against the oldest queued
// pattern. Directed tests cover reset defaults, packet framing, the escape
// byte, every command, stopped and zero-period timers, duty settings and a
// counter that carries over a period change; random traffic with both sides
// stalling follows.
// ----------------------------------------------------------------------------
module tb_top;
  import stp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 100_000;
  localparam int unsigned RANDOM_BEATS = 160;
  // Energized coils per index, four bits per entry, index 0 lowest
  localparam logic [31:0] COIL_MAP = 32'h98A2_6451;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [DutyW-1:0]  cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = '0;   // [7:0] rx_data
  logic              s_axis_tuser  = 1'b0; // [0] func
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // [9:0] duty_a1, [19:10] duty_a2, [29:20] duty_b1, [39:30] duty_b2,
  // [42:40] phase_index, [47:43] zero
  logic [47:0]       m_axis_tdata;
  logic              m_axis_tuser;         // [0] cause

  // Sequencer model state
  logic [DutyW-1:0]   duty_q    = OnDutyReset;
  logic [2:0]         grp_cnt   = '0;
  logic [7:0]         grp_bytes [4];
  logic [PeriodW-1:0] period_q  = PeriodReset;
  logic [PeriodW-1:0] ticks_q   = '0;
  logic               timer_on  = 1'b1;
  stp_dir_e           dir_q     = DirHold;
  logic [IdxW-1:0]    phase_q   = '0;

  stp_result_t pending_patterns [$];
  int unsigned predicted_cnt  = 0;
  int unsigned checked_cnt    = 0;
  int unsigned beats_sent     = 0;
  int unsigned duty_writes    = 0;
  int unsigned errors         = 0;
  int unsigned cycle_cnt      = 0;
  bit          src_idle       = 1'b1;
  bit          sink_stall     = 1'b1;

  stepper_half_step_packet_controller u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Clock and run limit
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: run limit reached with %0d patterns pending", $time,
               pending_patterns.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  // Receiver backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= !sink_stall || ($urandom_range(0, 99) >= 33);
  end

  // Coil pattern for one index at the current duty
  function automatic stp_result_t pattern_beat(input logic [IdxW-1:0] idx,
                                               input logic why);
    stp_result_t beat;
    logic [3:0]  coils;
    coils            = COIL_MAP[idx*4 +: 4];
    beat.duty_a1     = coils[0] ? duty_q : '0;
    beat.duty_a2     = coils[1] ? duty_q : '0;
    beat.duty_b1     = coils[2] ? duty_q : '0;
    beat.duty_b2     = coils[3] ? duty_q : '0;
    beat.phase_index = idx;
    beat.cause       = why;
    return beat;
  endfunction

  function automatic void queue_pattern(input logic why);
    pending_patterns.push_back(pattern_beat(phase_q, why));
    predicted_cnt++;
  endfunction

  // Advance the sequencer model by one accepted input beat
  task automatic advance_sequencer(input logic func, input logic [7:0] rx);
    logic [7:0] cmd;
    logic [7:0] hi;
    logic [7:0] lo;
    if (func) begin
      // timer tick
      if (!timer_on || period_q == '0) return;
      if (ticks_q == period_q) begin
        ticks_q = '0;
        queue_pattern(CauseTimed);
        if (dir_q == DirCcw) phase_q = phase_q - 3'd1;
        else if (dir_q == DirCw) phase_q = phase_q + 3'd1;
      end else begin
        ticks_q = ticks_q + 16'd1;
      end
      return;
    end
    // serial byte: gather four, the fifth is the escape
    if (grp_cnt < 3'd4) begin
      grp_bytes[grp_cnt[1:0]] = rx;
      grp_cnt = grp_cnt + 3'd1;
      return;
    end
    grp_cnt = '0;
    if (grp_bytes[0] != StartByte) return;
    cmd   = grp_bytes[1];
    hi    = rx[1] ? 8'hFF : grp_bytes[2];
    lo    = rx[0] ? 8'hFF : grp_bytes[3];
    dir_q = (cmd == CmdRunCcw) ? DirCcw : (cmd == CmdRunCw) ? DirCw : DirHold;
    case (cmd)
      CmdRunCcw: begin
        timer_on = 1'b1;
        period_q = {hi, lo};
        phase_q  = phase_q - 3'd1;
      end
      CmdRunCw: begin
        timer_on = 1'b1;
        period_q = {hi, lo};
        phase_q  = phase_q + 3'd1;
      end
      CmdStepCcw: begin
        timer_on = 1'b0;
        phase_q  = phase_q - 3'd1;
        queue_pattern(CauseSingle);
      end
      CmdStepCw: begin
        timer_on = 1'b0;
        phase_q  = phase_q + 3'd1;
        queue_pattern(CauseSingle);
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string what, input int unsigned want,
                               input int unsigned seen);
    if (want != seen) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, seen);
      errors++;
    end
  endtask

  // Check one output beat against the oldest queued pattern
  task automatic check_pattern();
    stp_result_t want;
    stp_result_t seen;
    seen = stp_result_t'({m_axis_tuser, m_axis_tdata[42:0]});
    if (pending_patterns.size() == 0) begin
      $display("%0t: unexpected beat, expected none, actual index %0d cause %0d",
               $time, seen.phase_index, seen.cause);
      errors++;
      return;
    end
    want = pending_patterns.pop_front();
    checked_cnt++;
    compare_field("duty_a1", want.duty_a1, seen.duty_a1);
    compare_field("duty_a2", want.duty_a2, seen.duty_a2);
    compare_field("duty_b1", want.duty_b1, seen.duty_b1);
    compare_field("duty_b2", want.duty_b2, seen.duty_b2);
    compare_field("phase_index", want.phase_index, seen.phase_index);
    compare_field("cause", want.cause, seen.cause);
  endtask

  // Handshakes sampled mid-cycle, where all signals are settled for the
  // coming rising edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_pattern();
      if (s_axis_tvalid && s_axis_tready) advance_sequencer(s_axis_tuser, s_axis_tdata);
    end
  end

  // Send one beat; called and returns at a rising edge
  task automatic send_beat(input logic func, input logic [7:0] rx);
    logic took;
    while (src_idle && $urandom_range(0, 99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= rx;
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end while (!took);
    beats_sent++;
  endtask

  task automatic send_frame(input logic [7:0] start, input logic [7:0] cmd,
                            input logic [7:0] hi, input logic [7:0] lo,
                            input logic [7:0] esc);
    send_beat(1'b0, start);
    send_beat(1'b0, cmd);
    send_beat(1'b0, hi);
    send_beat(1'b0, lo);
    send_beat(1'b0, esc);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_beat(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // Tick until the timer fires once
  task automatic ticks_until_step();
    int unsigned seen_cnt;
    seen_cnt = predicted_cnt;
    while (predicted_cnt == seen_cnt) send_beat(1'b1, 8'h00);
  endtask

  // Drop valid and wait for all queued patterns, bounded
  task automatic settle();
    int unsigned waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_patterns.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    if (pending_patterns.size() != 0) begin
      $display("%0t: %0d expected patterns never arrived", $time,
               pending_patterns.size());
      errors++;
      pending_patterns.delete();
    end
  endtask

  task automatic write_duty(input logic [DutyW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    duty_q       = value;
    duty_writes++;
  endtask

  // Timer runs from reset at the default period; a short burst stays below it
  task automatic test_reset_period();
    send_ticks(40);
    settle();
  endtask

  // Bad start, single steps, unknown command, zero period
  task automatic test_packet_framing();
    send_frame(8'h00, CmdStepCw, 8'h00, 8'h00, 8'h00);
    send_frame(StartByte, CmdStepCw, 8'hFF, 8'h00, 8'h00);
    send_frame(StartByte, CmdStepCcw, 8'h00, 8'hFF, 8'hFC);
    send_frame(StartByte, 8'hFF, 8'h12, 8'h34, 8'h00);
    send_frame(StartByte, CmdRunCw, 8'h00, 8'h00, 8'h00);
    send_ticks(4);
    settle();
  endtask

  // Escape forcing, continuous runs both ways, hold and stopped timer
  task automatic test_escape_and_run();
    send_frame(StartByte, CmdRunCcw, 8'h00, 8'h00, 8'h01);
    ticks_until_step();
    send_frame(StartByte, CmdRunCw, 8'h00, 8'h07, 8'h02);
    send_frame(StartByte, CmdRunCw, 8'h00, 8'h00, 8'h03);
    send_frame(StartByte, CmdRunCw, 8'h00, 8'h03, 8'h00);
    send_ticks(12);
    send_frame(StartByte, 8'h55, 8'h00, 8'h00, 8'h00);
    send_ticks(8);
    send_frame(StartByte, CmdStepCw, 8'h00, 8'h00, 8'h00);
    send_ticks(6);
    settle();
  endtask

  // Duty extremes, including a value above the nominal range
  task automatic test_duty_settings();
    logic [DutyW-1:0] values [4];
    values = '{10'd0, 10'd1000, 10'd1023, 10'd1};
    foreach (values[i]) begin
      write_duty(values[i]);
      send_frame(StartByte, CmdStepCw, 8'h00, 8'h00, 8'h00);
      send_frame(StartByte, CmdStepCcw, 8'h00, 8'h00, 8'h00);
      send_frame(StartByte, CmdStepCw, 8'h00, 8'h00, 8'h00);
      settle();
    end
    write_duty(OnDutyReset);
  endtask

  // A new period keeps the running count, so the first step comes early
  task automatic test_counter_kept();
    src_idle   = 1'b0;
    sink_stall = 1'b0;
    send_frame(StartByte, CmdRunCw, 8'h00, 8'd40, 8'h00);
    while (ticks_q != 16'd30) send_beat(1'b1, 8'h00);
    send_frame(StartByte, CmdRunCcw, 8'h00, 8'd35, 8'h00);
    ticks_until_step();
    ticks_until_step();
    settle();
    src_idle   = 1'b1;
    sink_stall = 1'b1;
  endtask

  // Mostly well-formed packets with random content, tick bursts, noise
  task automatic test_random_traffic();
    int unsigned first;
    int unsigned next_cfg;
    int unsigned pick;
    logic [7:0]   cmd;
    logic [7:0]   esc;
    logic [15:0]  per;
    first      = beats_sent;
    next_cfg   = 80;
    src_idle   = 1'b0;
    sink_stall = 1'b0;
    while (beats_sent - first < RANDOM_BEATS) begin
      if (beats_sent - first >= 60) begin
        src_idle   = 1'b1;
        sink_stall = 1'b1;
      end
      if (beats_sent - first >= next_cfg) begin
        settle();
        write_duty(10'($urandom_range(0, 1023)));
        next_cfg += 80;
      end
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        // finish any partial group so the packet lines up
        while (grp_cnt != 3'd0) send_beat(1'b0, 8'($urandom_range(0, 255)));
        case ($urandom_range(0, 9))
          0, 1, 2: cmd = CmdRunCcw;
          3, 4, 5: cmd = CmdRunCw;
          6:       cmd = CmdStepCcw;
          7:       cmd = CmdStepCw;
          8:       cmd = 8'($urandom_range(5, 255));
          default: cmd = 8'h00;
        endcase
        case ($urandom_range(0, 19))
          0:       per = '0;
          1:       per = 16'($urandom);
          default: per = ticks_q + 16'($urandom_range(0, 15));
        endcase
        esc = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 7) != 0) esc[1:0] = 2'b00;
        send_frame(StartByte, cmd, per[15:8], per[7:0], esc);
        send_ticks($urandom_range(0, 24));
      end else if (pick <= 7) begin
        send_ticks($urandom_range(1, 24));
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 4)) send_beat(1'b0, 8'($urandom_range(0, 255)));
      end else begin
        send_frame(8'($urandom_range(0, 254)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
      end
    end
    settle();
  endtask

  // Test sequence
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_period();
    test_packet_framing();
    test_escape_and_run();
    test_duty_settings();
    test_counter_kept();
    test_random_traffic();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d byte and tick beats, checked %0d coil patterns,", beats_sent,
             checked_cnt);
    $display("over %0d duty writes, packet framing, escapes and a kept tick count.",
             duty_writes);
    if (errors == 0 && pending_patterns.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/stp_pkg.sv
rtl/core/stp_core.sv
rtl/core/stp_skid.sv
rtl/core/stepper_half_step_packet_controller.sv
bench/tb_top.sv
